[rtl/mawf_pkg.sv]
// ----------------------------------------------------------------------------
// mawf_pkg
// shared types, constants and crc helpers for the modbus analog write framer
// ----------------------------------------------------------------------------
package mawf_pkg;

  localparam int unsigned FRAME_LEN = 8;

  localparam logic [7:0]  FUNC_WRITE_SINGLE = 8'h06;
  localparam logic [15:0] CRC_POLY          = 16'hA001;
  localparam logic [15:0] CRC_INIT          = 16'hFFFF;

  // register reset values
  localparam logic [7:0]  ADDR_RESET   = 8'd1;
  localparam logic [15:0] OFFSET_RESET = 16'd400;
  localparam logic [15:0] CLAMP_RESET  = 16'd1600;

  // divide by constant via reciprocal multiply, exact for 20-bit inputs
  localparam logic [19:0] DIV10_MULT  = 20'd838861;   // ceil(2^23 / 10)
  localparam int unsigned DIV10_SHIFT = 23;
  localparam logic [19:0] DIV100_MULT = 20'd671089;   // ceil(2^26 / 100)
  localparam int unsigned DIV100_SHIFT = 26;

  typedef enum logic [1:0] {
    REG_SLAVE_ADDRESS = 2'd0,
    REG_OUTPUT_OFFSET = 2'd1,
    REG_CLAMP_LIMIT   = 2'd2,
    REG_UNUSED        = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    CH_COD = 2'd0,
    CH_BOD = 2'd1,
    CH_TP  = 2'd2,
    CH_TN  = 2'd3
  } chan_t;

  typedef struct packed {
    chan_t       chan;
    logic [19:0] scaled;
    logic [15:0] crc;
  } scaled_t;

  typedef struct packed {
    chan_t       chan;
    logic [15:0] word;
    logic [15:0] crc;
  } word_t;

  // crc-16/modbus table entry, eight shift steps
  function automatic logic [15:0] crc_tab(input logic [7:0] idx);
    logic [15:0] c;
    c = {8'h00, idx};
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // one byte through the reflected crc
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] t;
    t = crc_tab(crc[7:0] ^ data);
    return (crc >> 8) ^ t;
  endfunction

endpackage

[rtl/mawf_scale.sv]
// ----------------------------------------------------------------------------
// mawf_scale
// three-stage pipe: input register, reciprocal multiply, scale select
// ----------------------------------------------------------------------------
module mawf_scale import mawf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  slave_address,
  input  logic        in_valid,
  output logic        in_ready,
  input  chan_t       in_chan,
  input  logic [19:0] in_centi,
  output logic        out_valid,
  input  logic        out_ready,
  output scaled_t     out_data
);

  logic        v1, v2, v3;
  logic        rdy1, rdy2, rdy3;
  chan_t       chan1, chan2;
  logic [19:0] centi1, centi2;
  logic [16:0] q10;
  logic [13:0] q100;
  logic [15:0] crc2;
  logic [39:0] prod10, prod100;
  logic [19:0] scaled_next;

  assign rdy3     = !v3 || out_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  assign prod10  = 40'(centi1) * 40'(DIV10_MULT);
  assign prod100 = 40'(centi1) * 40'(DIV100_MULT);

  always_comb begin
    unique case (chan2)
      CH_TP:   scaled_next = centi2;
      CH_TN:   scaled_next = {3'b000, q10};
      default: scaled_next = {6'b000000, q100};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
    if (rdy1 && in_valid) begin
      chan1  <= in_chan;
      centi1 <= in_centi;
    end
    if (rdy2 && v1) begin
      chan2  <= chan1;
      centi2 <= centi1;
      q10    <= prod10[DIV10_SHIFT +: 17];
      q100   <= prod100[DIV100_SHIFT +: 14];
      crc2   <= crc_byte(crc_byte(CRC_INIT, slave_address), FUNC_WRITE_SINGLE);
    end
    if (rdy3 && v2) begin
      out_data.chan   <= chan2;
      out_data.scaled <= scaled_next;
      out_data.crc    <= crc_byte(crc_byte(crc2, 8'h00), {6'b000000, chan2});
    end
  end

  assign out_valid = v3;

endmodule

[rtl/mawf_word.sv]
// ----------------------------------------------------------------------------
// mawf_word
// clamp or offset the scaled reading into the 16-bit register value
// ----------------------------------------------------------------------------
module mawf_word import mawf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [15:0] output_offset,
  input  logic [15:0] clamp_limit,
  input  logic        in_valid,
  output logic        in_ready,
  input  scaled_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output word_t       out_data
);

  logic        v;
  logic [15:0] word_next;

  assign in_ready = !v || out_ready;

  always_comb begin
    if (in_data.scaled < {4'b0000, clamp_limit}) begin
      word_next = in_data.scaled[15:0] + output_offset;
    end else begin
      word_next = clamp_limit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (in_ready) begin
      v <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_data.chan <= in_data.chan;
      out_data.word <= word_next;
      out_data.crc  <= in_data.crc;
    end
  end

  assign out_valid = v;

endmodule

[rtl/mawf_ser.sv]
// ----------------------------------------------------------------------------
// mawf_ser
// finish the crc, hold the eight-byte frame, send a byte a cycle when ready
// ----------------------------------------------------------------------------
module mawf_ser import mawf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  slave_address,
  input  logic        in_valid,
  output logic        in_ready,
  input  word_t       in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_last
);

  localparam int unsigned CNT_W = $clog2(FRAME_LEN);

  logic             fv;
  logic [CNT_W-1:0] cnt;
  logic [8*FRAME_LEN-1:0] frame;
  logic [15:0]      crc_fin;
  logic             take;

  assign out_last  = (cnt == CNT_W'(FRAME_LEN - 1));
  assign take      = fv && out_ready;
  assign in_ready  = !fv || (take && out_last);
  assign out_valid = fv;
  assign out_byte  = frame[{cnt, 3'b000} +: 8];

  assign crc_fin = crc_byte(crc_byte(in_data.crc, in_data.word[15:8]), in_data.word[7:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      fv  <= 1'b0;
      cnt <= '0;
    end else if (in_ready && in_valid) begin
      fv  <= 1'b1;
      cnt <= '0;
    end else if (take) begin
      if (out_last) fv <= 1'b0;
      cnt <= cnt + CNT_W'(1);
    end
    if (in_ready && in_valid) begin
      frame <= {crc_fin[15:8], crc_fin[7:0], in_data.word[7:0], in_data.word[15:8],
                {6'b000000, in_data.chan}, 8'h00, FUNC_WRITE_SINGLE, slave_address};
    end
  end

endmodule

[rtl/modbus_analog_write_frame_core.sv]
// ----------------------------------------------------------------------------
// modbus_analog_write_frame_core
// builds a modbus rtu write-single-register frame from a scaled reading
// ----------------------------------------------------------------------------
// a request passes the three scale registers and the word register into the
// serializer frame, which loads the next frame only as the last byte is taken;
// the input side keeps taking requests into the 4-deep pipe while a frame drains
// reset: pipe and serializer empty, slave_address 1, offset 400, clamp 1600
module modbus_analog_write_frame_core import mawf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [19:0] value_centi, [23:20] zero pad
  input  logic [1:0]  s_axis_tuser,   // [1:0] channel
  // frame byte stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] frame_byte
  output logic        m_axis_tlast,   // last_byte
  // register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [7:0]  slave_address;
  logic [15:0] output_offset;
  logic [15:0] clamp_limit;

  logic    sc_valid, sc_ready;
  scaled_t sc_data;
  logic    wd_valid, wd_ready;
  word_t   wd_data;

  // register file, writes always taken; the index past the list is dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address <= ADDR_RESET;
      output_offset <= OFFSET_RESET;
      clamp_limit   <= CLAMP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_index_t'(cfg_index))
        REG_SLAVE_ADDRESS: slave_address <= cfg_data[7:0];
        REG_OUTPUT_OFFSET: output_offset <= cfg_data;
        REG_CLAMP_LIMIT:   clamp_limit   <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register, reciprocal divide by 10 and 100, scale select,
  // crc over the address, function, register bytes
  mawf_scale u_scale (
    .clk           (clk),
    .rst           (rst),
    .slave_address (slave_address),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .in_chan       (chan_t'(s_axis_tuser)),
    .in_centi      (s_axis_tdata[19:0]),
    .out_valid     (sc_valid),
    .out_ready     (sc_ready),
    .out_data      (sc_data)
  );

  // clamp at the limit, otherwise add the offset with 16-bit wrap
  mawf_word u_word (
    .clk           (clk),
    .rst           (rst),
    .output_offset (output_offset),
    .clamp_limit   (clamp_limit),
    .in_valid      (sc_valid),
    .in_ready      (sc_ready),
    .in_data       (sc_data),
    .out_valid     (wd_valid),
    .out_ready     (wd_ready),
    .out_data      (wd_data)
  );

  // crc over the value bytes, frame hold, byte-wide shift out
  mawf_ser u_ser (
    .clk           (clk),
    .rst           (rst),
    .slave_address (slave_address),
    .in_valid      (wd_valid),
    .in_ready      (wd_ready),
    .in_data       (wd_data),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .out_byte      (m_axis_tdata),
    .out_last      (m_axis_tlast)
  );

endmodule
